// File: design/blocked_line_trace_core_macros.svh
// Assertion helpers shared by the line trace design.
// Every check is sampled on i_clk and is off while i_rst_n is low.
`ifndef BLOCKED_LINE_TRACE_CORE_MACROS_SVH
`define BLOCKED_LINE_TRACE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/blt_pkg.sv
package blt_pkg;

    localparam int COORD_W = 9;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TRACE = 1'b1;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic   cmd;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
        logic   blocked_bit;
    } t_blt_item;

    typedef struct packed {
        t_coord stop_x;
        t_coord stop_y;
        logic   reached;
    } t_blt_result;

endpackage

// File: design/blt_map.sv
module blt_map #(
    parameter int AW = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata,
    output logic          o_ready
);

    logic          mem [2**AW];
    logic [AW-1:0] r_clr_addr;
    logic          r_clearing;
    logic          r_rdata;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;

    // The sweep after reset owns the write port until every entry is free.
    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = 1'b0;
        end else begin
            wr_en   = i_we;
            wr_addr = i_waddr;
            wr_data = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clearing;

endmodule

// File: design/blocked_line_trace_core.sv
// Line-of-sight tracer over a one-bit obstacle map. A write beat sets or clears one map cell;
// a trace beat walks a Bresenham line from the start cell toward the end cell and delivers one
// result, on o_result for exactly one cycle while o_result_strobe is high, with no way for the
// receiver to hold it. A trace keeps busy high until the walk reaches the end cell or meets a
// solid cell: the walk reads one map bit per cycle from the single read port of the map memory.
// After reset the map is swept clear one cell per cycle, with busy high for the whole sweep.
`include "blocked_line_trace_core_macros.svh"

module blocked_line_trace_core #(
    parameter int GRID_W = 512,
    parameter int GRID_H = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  blt_pkg::t_blt_item     i_item,
    output logic                   o_result_strobe,
    output blt_pkg::t_blt_result   o_result
);

    localparam int CW = blt_pkg::COORD_W;
    localparam int XW = $clog2(GRID_W);
    localparam int YW = $clog2(GRID_H);
    localparam int AW = XW + YW;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_WALK
    } t_state;

    t_state          r_state;
    blt_pkg::t_coord r_sx, r_sy, r_ex, r_ey;
    blt_pkg::t_coord r_x, r_y, r_lx, r_ly;
    blt_pkg::t_coord r_err, r_long, r_short;
    logic [CW:0]     r_left;
    logic            r_xmaj, r_xneg, r_yneg, r_xmov, r_ymov;
    logic            r_chk_v, r_chk_in;
    blt_pkg::t_coord r_chk_x, r_chk_y;
    logic            r_res_v;
    blt_pkg::t_blt_result r_res;

    logic            accept;
    logic            map_we, map_rdata, map_ready;
    logic [AW-1:0]   map_waddr, map_raddr;

    logic [CW:0]     dx, dy;
    blt_pkg::t_coord adx, ady, su_long, su_short;
    logic            su_xmaj;

    logic [CW:0]     err_sum;
    logic            diag, move_x, move_y, chk_solid, cur_in;
    blt_pkg::t_coord n_x, n_y, n_err;

    logic            chk_x_box, chk_y_box;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign map_we = accept && (i_item.cmd == blt_pkg::CMD_WRITE)
                    && (32'(i_item.start_x) < GRID_W) && (32'(i_item.start_y) < GRID_H);
    assign map_waddr = {YW'(i_item.start_y), XW'(i_item.start_x)};
    assign map_raddr = {YW'(r_y), XW'(r_x)};

    blt_map #(
        .AW(AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (i_item.blocked_bit),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata),
        .o_ready (map_ready)
    );

    // Spans and direction of the line, taken from the latched beat.
    always_comb begin
        dx       = {1'b0, r_ex} - {1'b0, r_sx};
        dy       = {1'b0, r_ey} - {1'b0, r_sy};
        adx      = dx[CW] ? CW'(-dx) : CW'(dx);
        ady      = dy[CW] ? CW'(-dy) : CW'(dy);
        su_xmaj  = (adx > ady);
        su_long  = su_xmaj ? adx : ady;
        su_short = su_xmaj ? ady : adx;
    end

    // One Bresenham step from the point whose read goes out this cycle. The error stays below
    // the longer span, so the sum never needs more than one extra bit.
    always_comb begin
        err_sum = {1'b0, r_err} + {1'b0, r_short};
        diag    = (err_sum >= {1'b0, r_long});
        n_err   = diag ? CW'(err_sum - {1'b0, r_long}) : CW'(err_sum);
        move_x  = diag ? r_xmov : r_xmaj;
        move_y  = diag ? r_ymov : !r_xmaj;
        n_x     = move_x ? (r_xneg ? r_x - CW'(1) : r_x + CW'(1)) : r_x;
        n_y     = move_y ? (r_yneg ? r_y - CW'(1) : r_y + CW'(1)) : r_y;
        cur_in  = (32'(r_x) < GRID_W) && (32'(r_y) < GRID_H);
    end

    // Cells outside the grid count as solid.
    assign chk_solid = !r_chk_in || map_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_res_v <= 1'b0;
            r_chk_v <= 1'b0;
        end else begin
            r_res_v <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (map_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && i_item.cmd == blt_pkg::CMD_TRACE) begin
                        r_sx    <= i_item.start_x;
                        r_sy    <= i_item.start_y;
                        r_ex    <= i_item.end_x;
                        r_ey    <= i_item.end_y;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_x     <= r_sx;
                    r_y     <= r_sy;
                    r_lx    <= r_sx;
                    r_ly    <= r_sy;
                    r_long  <= su_long;
                    r_short <= su_short;
                    r_err   <= su_long >> 1;
                    r_left  <= {1'b0, su_long} + (CW+1)'(1);
                    r_xmaj  <= su_xmaj;
                    r_xneg  <= dx[CW];
                    r_yneg  <= dy[CW];
                    r_xmov  <= (dx != '0);
                    r_ymov  <= (dy != '0);
                    r_chk_v <= 1'b0;
                    if (r_sx == r_ex && r_sy == r_ey) begin
                        r_res.stop_x  <= r_sx;
                        r_res.stop_y  <= r_sy;
                        r_res.reached <= 1'b1;
                        r_res_v       <= 1'b1;
                        r_state       <= S_IDLE;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // The read for the next point is already out while this one is checked;
                    // a solid cell drops it along with the rest of the walk.
                    if (r_chk_v && chk_solid) begin
                        r_res.stop_x  <= r_lx;
                        r_res.stop_y  <= r_ly;
                        r_res.reached <= (r_lx == r_ex) && (r_ly == r_ey);
                        r_res_v       <= 1'b1;
                        r_chk_v       <= 1'b0;
                        r_state       <= S_IDLE;
                    end else if (!r_chk_v && r_left == '0) begin
                        r_res.stop_x  <= r_lx;
                        r_res.stop_y  <= r_ly;
                        r_res.reached <= (r_lx == r_ex) && (r_ly == r_ey);
                        r_res_v       <= 1'b1;
                        r_state       <= S_IDLE;
                    end else begin
                        if (r_chk_v) begin
                            r_lx <= r_chk_x;
                            r_ly <= r_chk_y;
                        end
                        if (r_left != '0) begin
                            r_chk_v  <= 1'b1;
                            r_chk_x  <= r_x;
                            r_chk_y  <= r_y;
                            r_chk_in <= cur_in;
                            r_x      <= n_x;
                            r_y      <= n_y;
                            r_err    <= n_err;
                            r_left   <= r_left - (CW+1)'(1);
                        end else begin
                            r_chk_v <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_strobe = r_res_v;
    assign o_result        = r_res;

    assign chk_x_box = (r_chk_x >= r_sx && r_chk_x <= r_ex)
                       || (r_chk_x <= r_sx && r_chk_x >= r_ex);
    assign chk_y_box = (r_chk_y >= r_sy && r_chk_y <= r_ey)
                       || (r_chk_y <= r_sy && r_chk_y >= r_ey);

    `BLT_ASSERT_SAME(a_chk_in_box, r_chk_v, chk_x_box && chk_y_box, "checked cell left the box")
    `BLT_ASSERT_SAME(a_busy_clear, !map_ready, busy, "block idle while the map is being cleared")
    `BLT_ASSERT_NEXT(a_one_strobe, o_result_strobe, !o_result_strobe, "two result beats in a row")

endmodule
